[sv/bscl_pkg.sv]
// bscl_pkg: shared widths, codes, reset values and the outline corner table
// for the box silhouette corner lookup.
// No dependencies; used by the interfaces and the top level.
package bscl_pkg;

    // field widths
    localparam int CAM_W     = 16;
    localparam int D_W       = CAM_W + 1;      // camera minus centre
    localparam int AXIS_W    = 16;             // signed Q1.14
    localparam int PROD_W    = D_W + AXIS_W;   // one product
    localparam int SUM_W     = PROD_W + 2;     // sum of three products
    localparam int CMP_W     = SUM_W + 1;      // compare width
    localparam int HALF_W    = 16;             // unsigned Q8.8
    localparam int HALF_SH   = 14;             // Q8.8 to Q.22 alignment
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CODE_W    = 6;
    localparam int CORNER_W  = 3;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = 3;
    localparam int MAX_CORNERS = 6;
    localparam int AXES      = 3;

    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CORNER_W-1:0]  t_corner;
    typedef logic [CNT_W-1:0]     t_count;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CODE_W-1:0]    t_code;

    // result status codes
    localparam t_status STATUS_CORNER  = 2'd0;
    localparam t_status STATUS_INSIDE  = 2'd1;
    localparam t_status STATUS_INVALID = 2'd2;

    // register indexes
    localparam t_cfg_idx REG_AXIS_FRONT  = 3'd0;
    localparam t_cfg_idx REG_AXIS_RIGHT  = 3'd1;
    localparam t_cfg_idx REG_AXIS_TOP    = 3'd2;
    localparam t_cfg_idx REG_BOX_CENTER  = 3'd3;
    localparam t_cfg_idx REG_HALF_EXTENT = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0] RST_AXIS_FRONT  = 48'h0000_0000_4000;
    localparam logic [CFG_W-1:0] RST_AXIS_RIGHT  = 48'h0000_4000_0000;
    localparam logic [CFG_W-1:0] RST_AXIS_TOP    = 48'h4000_0000_0000;
    localparam logic [CFG_W-1:0] RST_BOX_CENTER  = 48'h0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_HALF_EXTENT = 48'h0100_0100_0100;

    // one outline: corner count and corners in emission order
    typedef struct packed {
        t_count                        count;
        logic [MAX_CORNERS-1:0][CORNER_W-1:0] corner;
    } t_outline;

    function automatic t_outline mk_outline(input t_count n,
                                            input t_corner c0, input t_corner c1,
                                            input t_corner c2, input t_corner c3,
                                            input t_corner c4, input t_corner c5);
        t_outline o;
        o.count     = n;
        o.corner[0] = c0;
        o.corner[1] = c1;
        o.corner[2] = c2;
        o.corner[3] = c3;
        o.corner[4] = c4;
        o.corner[5] = c5;
        return o;
    endfunction

    // region code to outline; codes with no outline give a zero count
    function automatic t_outline outline_lookup(input t_code code);
        t_outline o;
        unique case (code)
            6'd1:    o = mk_outline(3'd4, 3'd0, 3'd4, 3'd7, 3'd3, 3'd0, 3'd0);
            6'd2:    o = mk_outline(3'd4, 3'd1, 3'd2, 3'd6, 3'd5, 3'd0, 3'd0);
            6'd4:    o = mk_outline(3'd4, 3'd0, 3'd1, 3'd5, 3'd4, 3'd0, 3'd0);
            6'd5:    o = mk_outline(3'd6, 3'd0, 3'd1, 3'd5, 3'd4, 3'd7, 3'd3);
            6'd6:    o = mk_outline(3'd6, 3'd0, 3'd1, 3'd2, 3'd6, 3'd5, 3'd4);
            6'd8:    o = mk_outline(3'd4, 3'd2, 3'd3, 3'd7, 3'd6, 3'd0, 3'd0);
            6'd9:    o = mk_outline(3'd6, 3'd4, 3'd7, 3'd6, 3'd2, 3'd3, 3'd0);
            6'd10:   o = mk_outline(3'd6, 3'd2, 3'd3, 3'd7, 3'd6, 3'd5, 3'd1);
            6'd16:   o = mk_outline(3'd4, 3'd0, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0);
            6'd17:   o = mk_outline(3'd6, 3'd0, 3'd4, 3'd7, 3'd3, 3'd2, 3'd1);
            6'd18:   o = mk_outline(3'd6, 3'd0, 3'd3, 3'd2, 3'd6, 3'd5, 3'd1);
            6'd20:   o = mk_outline(3'd6, 3'd0, 3'd3, 3'd2, 3'd1, 3'd5, 3'd4);
            6'd21:   o = mk_outline(3'd6, 3'd2, 3'd1, 3'd5, 3'd4, 3'd7, 3'd3);
            6'd22:   o = mk_outline(3'd6, 3'd0, 3'd3, 3'd2, 3'd6, 3'd5, 3'd4);
            6'd24:   o = mk_outline(3'd6, 3'd0, 3'd3, 3'd7, 3'd6, 3'd2, 3'd1);
            6'd25:   o = mk_outline(3'd6, 3'd0, 3'd4, 3'd7, 3'd6, 3'd2, 3'd1);
            6'd26:   o = mk_outline(3'd6, 3'd0, 3'd3, 3'd7, 3'd6, 3'd5, 3'd1);
            6'd32:   o = mk_outline(3'd4, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd0);
            6'd33:   o = mk_outline(3'd6, 3'd4, 3'd5, 3'd6, 3'd7, 3'd3, 3'd0);
            6'd34:   o = mk_outline(3'd6, 3'd1, 3'd2, 3'd6, 3'd7, 3'd4, 3'd5);
            6'd36:   o = mk_outline(3'd6, 3'd0, 3'd1, 3'd5, 3'd6, 3'd7, 3'd4);
            6'd37:   o = mk_outline(3'd6, 3'd0, 3'd1, 3'd5, 3'd6, 3'd7, 3'd3);
            6'd38:   o = mk_outline(3'd6, 3'd0, 3'd1, 3'd2, 3'd6, 3'd7, 3'd4);
            6'd40:   o = mk_outline(3'd6, 3'd2, 3'd3, 3'd7, 3'd4, 3'd5, 3'd6);
            6'd41:   o = mk_outline(3'd6, 3'd0, 3'd4, 3'd5, 3'd6, 3'd2, 3'd3);
            6'd42:   o = mk_outline(3'd6, 3'd1, 3'd2, 3'd3, 3'd7, 3'd4, 3'd5);
            default: o = mk_outline(3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0);
        endcase
        return o;
    endfunction

endpackage

[sv/bscl_if.sv]
// bscl_if: valid/ready channel interfaces for camera items, corner results
// and configuration writes.
// Depends on bscl_pkg.
interface bscl_cam_if;
    logic                                valid;
    logic                                ready;
    logic signed [bscl_pkg::CAM_W-1:0]   cam_x;
    logic signed [bscl_pkg::CAM_W-1:0]   cam_y;
    logic signed [bscl_pkg::CAM_W-1:0]   cam_z;
    modport source (output valid, output cam_x, output cam_y, output cam_z, input ready);
    modport sink   (input valid, input cam_x, input cam_y, input cam_z, output ready);
endinterface

interface bscl_corner_if;
    logic                  valid;
    logic                  ready;
    bscl_pkg::t_corner     corner;
    bscl_pkg::t_status     status;
    logic                  last;
    modport source (output valid, output corner, output status, output last, input ready);
    modport sink   (input valid, input corner, input status, input last, output ready);
endinterface

interface bscl_cfg_if;
    logic                          valid;
    logic                          ready;
    bscl_pkg::t_cfg_idx            index;
    logic [bscl_pkg::CFG_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/box_silhouette_corner_lookup.sv]
// box_silhouette_corner_lookup: camera position to box outline corner items.
// Result items leave the output register after the difference, product and
// sum registers. It gives an outline's 4 or 6 corners in turn, taking no new
// item until the last is taken; status items go one per cycle on o_res.ready.
// The three earlier stages take a new item every cycle unless held back.
// Reset (synchronous, active low) empties all stages and restores the registers.
module box_silhouette_corner_lookup (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bscl_cam_if.sink              i_cam,
    bscl_corner_if.source         o_res,
    bscl_cfg_if.sink              i_cfg
);

    // configuration registers
    logic [bscl_pkg::CFG_W-1:0] r_axis_front;
    logic [bscl_pkg::CFG_W-1:0] r_axis_right;
    logic [bscl_pkg::CFG_W-1:0] r_axis_top;
    logic [bscl_pkg::CFG_W-1:0] r_box_center;
    logic [bscl_pkg::CFG_W-1:0] r_half_extent;

    logic [bscl_pkg::CFG_W-1:0] w_axis [bscl_pkg::AXES];

    // stage 1: difference, stage 2: products, stage 3: sums, stage 4: output
    logic                                  r_d_v;
    logic signed [bscl_pkg::D_W-1:0]       r_d [bscl_pkg::AXES];
    logic signed [bscl_pkg::D_W-1:0]       n_d [bscl_pkg::AXES];
    logic                                  r_p_v;
    logic signed [bscl_pkg::PROD_W-1:0]    r_p [bscl_pkg::AXES][bscl_pkg::AXES];
    logic signed [bscl_pkg::PROD_W-1:0]    n_p [bscl_pkg::AXES][bscl_pkg::AXES];
    logic                                  r_t_v;
    logic signed [bscl_pkg::SUM_W-1:0]     r_t [bscl_pkg::AXES];
    logic signed [bscl_pkg::SUM_W-1:0]     n_t [bscl_pkg::AXES];
    logic                                  r_em_v;
    bscl_pkg::t_outline                    r_em;
    bscl_pkg::t_outline                    n_em;
    bscl_pkg::t_status                     r_em_status;
    bscl_pkg::t_status                     n_em_status;
    bscl_pkg::t_count                      r_idx;

    logic signed [bscl_pkg::CMP_W-1:0]     w_lim [bscl_pkg::AXES];
    logic signed [bscl_pkg::CMP_W-1:0]     w_tf;
    logic signed [bscl_pkg::CMP_W-1:0]     w_tr;
    logic signed [bscl_pkg::CMP_W-1:0]     w_tt;
    bscl_pkg::t_code                       w_code;
    bscl_pkg::t_outline                    w_outline;

    logic w_last;
    logic w_em_free;
    logic w_t_free;
    logic w_p_free;
    logic w_d_free;
    logic w_cam_take;

    assign w_axis[0] = r_axis_front;
    assign w_axis[1] = r_axis_right;
    assign w_axis[2] = r_axis_top;

    // flow control: each stage loads when empty or when it moves on
    assign w_last     = (r_idx == r_em.count - bscl_pkg::t_count'(1));
    assign w_em_free  = !r_em_v || (o_res.ready && w_last);
    assign w_t_free   = !r_t_v || w_em_free;
    assign w_p_free   = !r_p_v || w_t_free;
    assign w_d_free   = !r_d_v || w_p_free;
    assign i_cam.ready = w_d_free;
    assign w_cam_take = i_cam.valid && w_d_free;
    assign i_cfg.ready = 1'b1;

    // camera minus box centre
    always_comb begin
        n_d[0] = bscl_pkg::D_W'(i_cam.cam_x)
               - bscl_pkg::D_W'($signed(r_box_center[0 +: bscl_pkg::CAM_W]));
        n_d[1] = bscl_pkg::D_W'(i_cam.cam_y)
               - bscl_pkg::D_W'($signed(r_box_center[bscl_pkg::CAM_W +: bscl_pkg::CAM_W]));
        n_d[2] = bscl_pkg::D_W'(i_cam.cam_z)
               - bscl_pkg::D_W'($signed(r_box_center[2*bscl_pkg::CAM_W +: bscl_pkg::CAM_W]));
    end

    // nine products, one per axis and component
    always_comb begin
        for (int a = 0; a < bscl_pkg::AXES; a++) begin
            for (int k = 0; k < bscl_pkg::AXES; k++) begin
                n_p[a][k] = bscl_pkg::PROD_W'(r_d[k])
                          * bscl_pkg::PROD_W'($signed(w_axis[a][k*bscl_pkg::AXIS_W +:
                                                                bscl_pkg::AXIS_W]));
            end
        end
    end

    // box-frame coordinates: front, right, top
    always_comb begin
        for (int a = 0; a < bscl_pkg::AXES; a++) begin
            n_t[a] = bscl_pkg::SUM_W'(r_p[a][0]) + bscl_pkg::SUM_W'(r_p[a][1])
                   + bscl_pkg::SUM_W'(r_p[a][2]);
        end
    end

    // region code against the half extents, then table lookup
    always_comb begin
        for (int a = 0; a < bscl_pkg::AXES; a++) begin
            w_lim[a] = $signed({{(bscl_pkg::CMP_W - bscl_pkg::HALF_W - bscl_pkg::HALF_SH){1'b0}},
                                r_half_extent[a*bscl_pkg::HALF_W +: bscl_pkg::HALF_W],
                                {bscl_pkg::HALF_SH{1'b0}}});
        end
        w_tf = bscl_pkg::CMP_W'(r_t[0]);
        w_tr = bscl_pkg::CMP_W'(r_t[1]);
        w_tt = bscl_pkg::CMP_W'(r_t[2]);
        w_code[0] = (w_tr < -w_lim[1]);
        w_code[1] = (w_tr >  w_lim[1]);
        w_code[2] = (w_tt < -w_lim[2]);
        w_code[3] = (w_tt >  w_lim[2]);
        w_code[4] = (w_tf >  w_lim[0]);
        w_code[5] = (w_tf < -w_lim[0]);
        w_outline = bscl_pkg::outline_lookup(w_code);
        n_em = w_outline;
        n_em_status = bscl_pkg::STATUS_CORNER;
        if (w_code == '0) begin
            n_em        = bscl_pkg::mk_outline(3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0);
            n_em_status = bscl_pkg::STATUS_INSIDE;
        end else if (w_outline.count == '0) begin
            n_em        = bscl_pkg::mk_outline(3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0);
            n_em_status = bscl_pkg::STATUS_INVALID;
        end
    end

    // result item from the output register
    assign o_res.valid  = r_em_v;
    assign o_res.corner = r_em.corner[r_idx];
    assign o_res.status = r_em_status;
    assign o_res.last   = w_last;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_front  <= bscl_pkg::RST_AXIS_FRONT;
            r_axis_right  <= bscl_pkg::RST_AXIS_RIGHT;
            r_axis_top    <= bscl_pkg::RST_AXIS_TOP;
            r_box_center  <= bscl_pkg::RST_BOX_CENTER;
            r_half_extent <= bscl_pkg::RST_HALF_EXTENT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bscl_pkg::REG_AXIS_FRONT:  r_axis_front  <= i_cfg.data;
                bscl_pkg::REG_AXIS_RIGHT:  r_axis_right  <= i_cfg.data;
                bscl_pkg::REG_AXIS_TOP:    r_axis_top    <= i_cfg.data;
                bscl_pkg::REG_BOX_CENTER:  r_box_center  <= i_cfg.data;
                bscl_pkg::REG_HALF_EXTENT: r_half_extent <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // stage valids and output index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v  <= 1'b0;
            r_p_v  <= 1'b0;
            r_t_v  <= 1'b0;
            r_em_v <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (w_d_free) r_d_v <= i_cam.valid;
            if (w_p_free) r_p_v <= r_d_v;
            if (w_t_free) r_t_v <= r_p_v;
            if (w_em_free) begin
                r_em_v <= r_t_v;
                r_idx  <= '0;
            end else if (o_res.ready) begin
                r_idx <= r_idx + bscl_pkg::t_count'(1);
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_cam_take) r_d <= n_d;
        if (w_p_free)   r_p <= n_p;
        if (w_t_free)   r_t <= n_t;
        if (w_em_free) begin
            r_em        <= n_em;
            r_em_status <= n_em_status;
        end
    end

endmodule

[tb/sv/tb_box_silhouette_corner_lookup.sv]
`timescale 1ns / 1ps
// tb_box_silhouette_corner_lookup: self-checking bench for the box silhouette corner lookup.
// Items come from typed directed rows or are predicted from the camera and the registers.
// Depends on bscl_pkg, the bscl channel interfaces and box_silhouette_corner_lookup.
module tb_box_silhouette_corner_lookup;

    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 19;
    localparam int DIRECTED_ROWS = 25;
    localparam int DRAIN_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_PHASE    = 6;
    localparam int PAUSE_PHASE   = 2;
    localparam int CYCLE_LIMIT   = 250000;

    // Q1.14 axis components
    localparam logic [bscl_pkg::AXIS_W-1:0] Q14_ONE         = 16'h4000;
    localparam logic [bscl_pkg::AXIS_W-1:0] Q14_MINUS_ONE   = 16'hC000;
    localparam logic [bscl_pkg::AXIS_W-1:0] Q14_SIN45       = 16'h2D41;
    localparam logic [bscl_pkg::AXIS_W-1:0] Q14_MINUS_SIN45 = 16'hD2BF;

    typedef enum logic [1:0] {MODE_ORIENTED, MODE_EXTREME, MODE_BROAD, MODE_RANDOM} t_phase_mode;

    typedef struct packed {
        bscl_pkg::t_corner corner;
        bscl_pkg::t_status status;
        logic              last;
    } t_corner_item;

    // outline word: one nibble each for count and the six corners, in emission order
    typedef struct packed {
        logic [bscl_pkg::CAM_W-1:0] x;
        logic [bscl_pkg::CAM_W-1:0] y;
        logic [bscl_pkg::CAM_W-1:0] z;
        logic                       typed;
        bscl_pkg::t_status          status;
        logic [27:0]                outline;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    bscl_cam_if    cam_if ();
    bscl_corner_if res_if ();
    bscl_cfg_if    cfg_if ();

    box_silhouette_corner_lookup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cam   (cam_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // register copies used for prediction
    logic [bscl_pkg::CFG_W-1:0] front_axis;
    logic [bscl_pkg::CFG_W-1:0] right_axis;
    logic [bscl_pkg::CFG_W-1:0] top_axis;
    logic [bscl_pkg::CFG_W-1:0] centre_pos;
    logic [bscl_pkg::CFG_W-1:0] half_size;

    t_corner_item corners_due [$];

    int mismatches    = 0;
    int items_sent    = 0;
    int reg_writes    = 0;
    int outline_items = 0;
    int inside_items  = 0;
    int invalid_items = 0;
    int hold_ask      = 0;
    int hold_begun    = 0;
    int cycle_count   = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint sx16(input logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint project_on(input logic [bscl_pkg::CFG_W-1:0] axis,
                                          input longint d0, input longint d1,
                                          input longint d2);
        return d0 * sx16(axis[15:0]) + d1 * sx16(axis[31:16]) + d2 * sx16(axis[47:32]);
    endfunction

    // append one expected result item to the queue
    function automatic void append_due(input t_corner_item e);
        corners_due = {corners_due, e};
    endfunction

    // region code to outline word, zero count where there is no outline
    function automatic logic [27:0] silhouette_of(input bscl_pkg::t_code code);
        logic [27:0] w;
        unique case (code)
            6'd1:    w = 28'h4047300;
            6'd2:    w = 28'h4126500;
            6'd4:    w = 28'h4015400;
            6'd5:    w = 28'h6015473;
            6'd6:    w = 28'h6012654;
            6'd8:    w = 28'h4237600;
            6'd9:    w = 28'h6476230;
            6'd10:   w = 28'h6237651;
            6'd16:   w = 28'h4032100;
            6'd17:   w = 28'h6047321;
            6'd18:   w = 28'h6032651;
            6'd20:   w = 28'h6032154;
            6'd21:   w = 28'h6215473;
            6'd22:   w = 28'h6032654;
            6'd24:   w = 28'h6037621;
            6'd25:   w = 28'h6047621;
            6'd26:   w = 28'h6037651;
            6'd32:   w = 28'h4456700;
            6'd33:   w = 28'h6456730;
            6'd34:   w = 28'h6126745;
            6'd36:   w = 28'h6015674;
            6'd37:   w = 28'h6015673;
            6'd38:   w = 28'h6012674;
            6'd40:   w = 28'h6237456;
            6'd41:   w = 28'h6045623;
            6'd42:   w = 28'h6123745;
            default: w = 28'h0;
        endcase
        return w;
    endfunction

    // box-frame compare against the half sizes, then table lookup
    function automatic void predict_outline(input logic [bscl_pkg::CAM_W-1:0] cx,
                                            input logic [bscl_pkg::CAM_W-1:0] cy,
                                            input logic [bscl_pkg::CAM_W-1:0] cz,
                                            output bscl_pkg::t_status st,
                                            output logic [27:0] ol);
        longint          d0, d1, d2, tf, tr, tt, ha, hb, hc;
        bscl_pkg::t_code code;
        d0 = sx16(cx) - sx16(centre_pos[15:0]);
        d1 = sx16(cy) - sx16(centre_pos[31:16]);
        d2 = sx16(cz) - sx16(centre_pos[47:32]);
        tf = project_on(front_axis, d0, d1, d2);
        tr = project_on(right_axis, d0, d1, d2);
        tt = project_on(top_axis, d0, d1, d2);
        ha = longint'(half_size[15:0]) << bscl_pkg::HALF_SH;
        hb = longint'(half_size[31:16]) << bscl_pkg::HALF_SH;
        hc = longint'(half_size[47:32]) << bscl_pkg::HALF_SH;
        code = '0;
        if (tr < -hb) code[0] = 1'b1;
        if (tr > hb)  code[1] = 1'b1;
        if (tt < -hc) code[2] = 1'b1;
        if (tt > hc)  code[3] = 1'b1;
        if (tf > ha)  code[4] = 1'b1;
        if (tf < -ha) code[5] = 1'b1;
        ol = silhouette_of(code);
        if (code == '0)
            st = bscl_pkg::STATUS_INSIDE;
        else if (ol[27:24] == 4'd0)
            st = bscl_pkg::STATUS_INVALID;
        else
            st = bscl_pkg::STATUS_CORNER;
    endfunction

    // expand one outcome into the corner items it produces
    function automatic void queue_outline(input bscl_pkg::t_status st, input logic [27:0] ol);
        t_corner_item e;
        int n;
        if (st != bscl_pkg::STATUS_CORNER) begin
            e.corner = '0;
            e.status = st;
            e.last   = 1'b1;
            append_due(e);
        end else begin
            n = int'(ol[27:24]);
            for (int k = 0; k < n; k++) begin
                e.corner = ol[20-4*k +: 3];
                e.status = bscl_pkg::STATUS_CORNER;
                e.last   = (k == n - 1);
                append_due(e);
            end
        end
    endfunction

    function automatic int idle_gap(input logic quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // directed rows, all at the reset register values
    function automatic t_dir_row directed_row(input int i);
        t_dir_row r;
        unique case (i)
            // centre of the box
            0:  r = {16'h0000, 16'h0000, 16'h0000, 1'b1, bscl_pkg::STATUS_INSIDE, 28'h0};
            // one step beyond each face
            1:  r = {16'h0200, 16'h0000, 16'h0000, 1'b1, bscl_pkg::STATUS_CORNER, 28'h4032100};
            2:  r = {16'hFE00, 16'h0000, 16'h0000, 1'b1, bscl_pkg::STATUS_CORNER, 28'h4456700};
            3:  r = {16'h0000, 16'hFE00, 16'h0000, 1'b1, bscl_pkg::STATUS_CORNER, 28'h4047300};
            4:  r = {16'h0000, 16'h0200, 16'h0000, 1'b1, bscl_pkg::STATUS_CORNER, 28'h4126500};
            5:  r = {16'h0000, 16'h0000, 16'hFE00, 1'b1, bscl_pkg::STATUS_CORNER, 28'h4015400};
            6:  r = {16'h0000, 16'h0000, 16'h0200, 1'b1, bscl_pkg::STATUS_CORNER, 28'h4237600};
            // field extremes
            7:  r = {16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, bscl_pkg::STATUS_CORNER, 28'h6037651};
            8:  r = {16'h8000, 16'h8000, 16'h8000, 1'b1, bscl_pkg::STATUS_CORNER, 28'h6015673};
            // exactly on the faces counts as inside
            9:  r = {16'h0100, 16'h0100, 16'h0100, 1'b1, bscl_pkg::STATUS_INSIDE, 28'h0};
            10: r = {16'hFF00, 16'hFF00, 16'hFF00, 1'b1, bscl_pkg::STATUS_INSIDE, 28'h0};
            // one lsb past a face
            11: r = {16'h0101, 16'h0000, 16'h0000, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            12: r = {16'h0000, 16'hFEFF, 16'h0000, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            13: r = {16'h0000, 16'h0000, 16'h0101, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            // mixed extremes, corners and edges of the region grid
            14: r = {16'h7FFF, 16'h8000, 16'h0000, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            15: r = {16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            16: r = {16'h0200, 16'hFE00, 16'hFE00, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            17: r = {16'hFE00, 16'h0200, 16'hFE00, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            18: r = {16'h0200, 16'h0200, 16'h0200, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            19: r = {16'hFE00, 16'hFE00, 16'h0200, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            20: r = {16'h0000, 16'h0200, 16'hFE00, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            21: r = {16'h0200, 16'h0000, 16'hFE00, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            22: r = {16'hFE00, 16'h0000, 16'h0200, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            23: r = {16'h0000, 16'hFE00, 16'h0200, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
            default: r = {16'h5A5A, 16'hA5A5, 16'h0F0F, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0};
        endcase
        return r;
    endfunction

    function automatic t_phase_mode phase_mode(input int p);
        unique case (p)
            1:       return MODE_EXTREME;
            3:       return MODE_BROAD;
            5:       return MODE_RANDOM;
            default: return MODE_ORIENTED;
        endcase
    endfunction

    function automatic logic [bscl_pkg::CFG_W-1:0] unit_at(input int pos);
        logic [bscl_pkg::CFG_W-1:0] v;
        v = '0;
        v[16*pos +: 16] = ($urandom_range(0, 1) == 1) ? Q14_ONE : Q14_MINUS_ONE;
        return v;
    endfunction

    function automatic logic [bscl_pkg::CFG_W-1:0] random_reg();
        return {16'($urandom), $urandom};
    endfunction

    // camera near the box centre or anywhere in the field range
    function automatic void pick_camera(input t_phase_mode mode,
                                        output logic [bscl_pkg::CAM_W-1:0] cx,
                                        output logic [bscl_pkg::CAM_W-1:0] cy,
                                        output logic [bscl_pkg::CAM_W-1:0] cz);
        int near_pct;
        near_pct = (mode == MODE_ORIENTED) ? 80 : 30;
        if ($urandom_range(0, 99) < near_pct) begin
            cx = 16'(centre_pos[15:0] + $urandom_range(0, 32'h1800) - 32'h0C00);
            cy = 16'(centre_pos[31:16] + $urandom_range(0, 32'h1800) - 32'h0C00);
            cz = 16'(centre_pos[47:32] + $urandom_range(0, 32'h1800) - 32'h0C00);
        end else begin
            cx = 16'($urandom);
            cy = 16'($urandom);
            cz = 16'($urandom);
        end
    endfunction

    task automatic wait_drained();
        while (corners_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // offer one camera item, expectation taken at acceptance
    task automatic send_camera(input logic [bscl_pkg::CAM_W-1:0] cx,
                               input logic [bscl_pkg::CAM_W-1:0] cy,
                               input logic [bscl_pkg::CAM_W-1:0] cz, input logic typed,
                               input bscl_pkg::t_status st, input logic [27:0] ol,
                               input logic quiet);
        int                gap;
        bscl_pkg::t_status pst;
        logic [27:0]       pol;
        cam_if.valid <= 1'b1;
        cam_if.cam_x <= cx;
        cam_if.cam_y <= cy;
        cam_if.cam_z <= cz;
        @(posedge i_clk);
        while (cam_if.ready !== 1'b1)
            @(posedge i_clk);
        if (typed) begin
            queue_outline(st, ol);
        end else begin
            predict_outline(cx, cy, cz, pst, pol);
            queue_outline(pst, pol);
        end
        items_sent++;
        gap = idle_gap(quiet);
        if (gap > 0) begin
            cam_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input bscl_pkg::t_cfg_idx idx,
                             input logic [bscl_pkg::CFG_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge i_clk);
        unique case (idx)
            bscl_pkg::REG_AXIS_FRONT:  front_axis = val;
            bscl_pkg::REG_AXIS_RIGHT:  right_axis = val;
            bscl_pkg::REG_AXIS_TOP:    top_axis   = val;
            bscl_pkg::REG_BOX_CENTER:  centre_pos = val;
            bscl_pkg::REG_HALF_EXTENT: half_size  = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // new register setting for one phase, written while the block is idle
    task automatic program_phase(input t_phase_mode mode);
        logic [bscl_pkg::CFG_W-1:0] fa, ra, ta, ctr, hs;
        int perm, p0, p1, p2;
        unique case (mode)
            MODE_ORIENTED: begin
                if ($urandom_range(0, 3) == 0) begin
                    // 45 degree turn about the vertical axis
                    fa = {16'h0000, Q14_SIN45, Q14_SIN45};
                    ra = {16'h0000, Q14_SIN45, Q14_MINUS_SIN45};
                    ta = {Q14_ONE, 32'h0};
                end else begin
                    // signed permutation of the unit axes
                    perm = $urandom_range(0, 5);
                    p0 = perm % 3;
                    p1 = (p0 + 1 + perm / 3) % 3;
                    p2 = 3 - p0 - p1;
                    fa = unit_at(p0);
                    ra = unit_at(p1);
                    ta = unit_at(p2);
                end
                for (int k = 0; k < bscl_pkg::AXES; k++) begin
                    ctr[16*k +: 16] = 16'($urandom_range(0, 32'h4000) - 32'h2000);
                    hs[16*k +: 16]  = 16'($urandom_range(32'h0040, 32'h0400));
                end
            end
            MODE_EXTREME: begin
                fa  = {3{16'h7FFF}};
                ra  = {3{16'h8000}};
                ta  = {16'h7FFF, 16'h8000, 16'h0000};
                ctr = {16'h8000, 16'h7FFF, 16'h8000};
                hs  = '0;
            end
            MODE_BROAD: begin
                fa  = {32'h0, 16'h8000};
                ra  = {16'h0000, 16'h8000, 16'h0000};
                ta  = {16'h7FFF, 32'h0};
                ctr = {16'h7FFF, 16'h0000, 16'h8000};
                hs  = {3{16'hFFFF}};
            end
            default: begin
                fa  = random_reg();
                ra  = random_reg();
                ta  = random_reg();
                ctr = random_reg();
                hs  = random_reg();
            end
        endcase
        write_reg(bscl_pkg::REG_AXIS_FRONT, fa);
        write_reg(bscl_pkg::REG_AXIS_RIGHT, ra);
        write_reg(bscl_pkg::REG_AXIS_TOP, ta);
        write_reg(bscl_pkg::REG_BOX_CENTER, ctr);
        write_reg(bscl_pkg::REG_HALF_EXTENT, hs);
        // an index past the list must leave every register alone
        write_reg(bscl_pkg::t_cfg_idx'(bscl_pkg::REG_HALF_EXTENT + 1 + $urandom_range(0, 2)),
                  random_reg());
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result receiver with random stalls and one long hold-off on request
    initial begin : result_sink
        int hold_done, burst, gap;
        hold_done = 0;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_ask != hold_done) begin
                hold_done = hold_ask;
                hold_begun = hold_ask;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 10);
                res_if.ready <= 1'b1;
                repeat (burst) @(posedge i_clk);
                gap = idle_gap(1'b0);
                if (gap > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // compare each accepted result item with the oldest one due
    always @(posedge i_clk) begin : result_check
        t_corner_item e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (corners_due.size() == 0) begin
                $error("result item with nothing due: corner %0d status %0d last %0d",
                       res_if.corner, res_if.status, res_if.last);
                mismatches++;
            end else begin
                e = corners_due.pop_front();
                if (res_if.corner !== e.corner) begin
                    $error("corner: expected %0d, got %0d", e.corner, res_if.corner);
                    mismatches++;
                end
                if (res_if.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, res_if.status);
                    mismatches++;
                end
                if (res_if.last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, res_if.last);
                    mismatches++;
                end
                if (e.last && e.status == bscl_pkg::STATUS_CORNER) outline_items++;
                if (e.status == bscl_pkg::STATUS_INSIDE) inside_items++;
                if (e.status == bscl_pkg::STATUS_INVALID) invalid_items++;
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_dir_row                   row;
        t_phase_mode                mode;
        logic [bscl_pkg::CAM_W-1:0] cx, cy, cz;
        i_rst_n      = 1'b0;
        cam_if.valid = 1'b0;
        cam_if.cam_x = '0;
        cam_if.cam_y = '0;
        cam_if.cam_z = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        front_axis   = bscl_pkg::RST_AXIS_FRONT;
        right_axis   = bscl_pkg::RST_AXIS_RIGHT;
        top_axis     = bscl_pkg::RST_AXIS_TOP;
        centre_pos   = bscl_pkg::RST_BOX_CENTER;
        half_size    = bscl_pkg::RST_HALF_EXTENT;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at the reset setting
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_row(i);
            send_camera(row.x, row.y, row.z, row.typed, row.status, row.outline, 1'b0);
        end
        cam_if.valid <= 1'b0;

        // random phases, each with its own register setting
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            mode = phase_mode(p);
            program_phase(mode);
            if (p == HOLD_PHASE) begin
                // receiver stops before the sender starts offering
                hold_ask++;
                wait (hold_begun == hold_ask);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender waits for the block to empty half way through
                if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
                    cam_if.valid <= 1'b0;
                    wait_drained();
                end
                pick_camera(mode, cx, cy, cz);
                send_camera(cx, cy, cz, 1'b0, bscl_pkg::STATUS_CORNER, 28'h0,
                            p == HOLD_PHASE);
            end
            cam_if.valid <= 1'b0;
        end

        wait_drained();
        $display("covered %0d camera items over %0d register settings with %0d register writes",
                 items_sent, PHASES + 1, reg_writes);
        $display("seen %0d outlines, %0d inside, %0d invalid; %0d mismatches",
                 outline_items, inside_items, invalid_items, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
